/* rtl/core/csim_pkg.sv */
// Shared types and constants of the cosine similarity engine.
// Used by the front accumulator, the result queue and the root/divide back end.
package csim_pkg;

    // Input element and result widths
    localparam int ELEM_W = 16;
    localparam int SIM_W  = 16;

    // Accumulator widths (dot sum signed Q18.24, square sums unsigned Q17.24)
    localparam int DOT_W = 42;
    localparam int SQ_W  = 41;

    // Saturation limits of the accumulators
    localparam logic signed [DOT_W-1:0] DOT_MAX_C = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic signed [DOT_W-1:0] DOT_MIN_C = {1'b1, {(DOT_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]         SQ_MAX_C  = {SQ_W{1'b1}};

    // Result queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

    // Back end datapath widths
    localparam int MAG_W     = DOT_W;          // |dot| reaches 2^41
    localparam int PROD_W    = 2 * MAG_W - 1;  // dot^2 and sa*sb
    localparam int FRAC_BITS = 15;             // Q1.15 result fraction
    localparam int ROOT_BITS = FRAC_BITS;      // quotient bits below saturation
    localparam int ROOT_SHIFT = 2 * FRAC_BITS; // scale of dot^2
    localparam int T2_SHIFT  = 2 * (ROOT_BITS - 1);
    localparam int RW        = PROD_W + ROOT_SHIFT + 1;
    localparam int CNT_W     = $clog2(MAG_W);

    // Result codes
    localparam logic [SIM_W-1:0] SIM_MAX = {1'b0, {(SIM_W-1){1'b1}}};
    localparam logic [SIM_W-1:0] SIM_MIN = {1'b1, {(SIM_W-1){1'b0}}};

    // Finished accumulator set handed from front to back
    typedef struct packed {
        logic signed [DOT_W-1:0] dot_sum;
        logic [SQ_W-1:0]         square_sum_a;
        logic [SQ_W-1:0]         square_sum_b;
    } acc_entry_t;

endpackage

/* rtl/core/cosine_similarity_engine.sv */
// Top level of the cosine similarity engine.
// Instantiates csim_front, csim_queue and csim_back; uses csim_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one element pair per transaction,
//   elem_a and elem_b in signed Q4.12, last marks the final pair of a vector.
//   Output channel (out_valid / out_stall): one transaction per vector,
//   similarity in signed Q1.15 (+1 saturates to 32767) and zero_norm, set
//   with similarity 0 when either vector has zero length.
// Throughput: one element pair per cycle unless in_stall is high, set by the
//   multiply-accumulate front end. Pairs beyond MAX_LENGTH in one vector are ignored.
// Sequence: the back end pops a vector's sums, runs 42 shift-add steps, one
//   compare, 15 quotient bit steps and the output load (a saturating quotient
//   skips the bit steps, a zero-length vector goes straight to the load), and
//   pops no new vector before that load.
// Buffering: two finished vectors queue between front and back; when the
//   queue is full, counting vector ends in flight, in_stall rises. A stalled
//   receiver holds the output register and then the back end.
// Reset: asynchronous, active low; clears the sums, the count, the queue
//   and the output register.
module cosine_similarity_engine
    import csim_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_LENGTH  = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [SIM_W-1:0]  similarity,
    output logic                     zero_norm
);

    logic             push;
    acc_entry_t       push_data;
    logic             pop;
    logic             q_valid;
    acc_entry_t       q_data;
    logic [LVL_W-1:0] level;

    // Accumulate element pairs
    csim_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .last      (last),
        .level     (level),
        .push      (push),
        .push_data (push_data)
    );

    // Buffer finished sums
    csim_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .level     (level)
    );

    // Root and divide
    csim_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .zero_norm  (zero_norm)
    );

endmodule

/* rtl/core/csim_front.sv */
// Front end: accepts element pairs, multiplies and accumulates with saturation.
// Pushes the finished sums of each vector into the result queue. Uses csim_pkg.
module csim_front
    import csim_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_LENGTH  = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     last,
    input  logic [LVL_W-1:0]         level,
    output logic                     push,
    output acc_entry_t               push_data
);

    localparam int XW = (SAMPLE_BITS > ELEM_W) ? SAMPLE_BITS : ELEM_W;
    localparam int PW = 2 * SAMPLE_BITS;
    localparam int AW = ((PW > DOT_W) ? PW : DOT_W) + 1;
    localparam int CW = $clog2(MAX_LENGTH + 1);

    localparam logic signed [AW-1:0] DOT_HI = AW'(DOT_MAX_C);
    localparam logic signed [AW-1:0] DOT_LO = AW'(DOT_MIN_C);
    localparam logic [AW-1:0]        SQ_HI  = AW'(SQ_MAX_C);

    logic [XW-1:0]                a_ext;
    logic [XW-1:0]                b_ext;
    logic signed [SAMPLE_BITS-1:0] a_s;
    logic signed [SAMPLE_BITS-1:0] b_s;
    logic signed [PW-1:0]         ab_prod;
    logic signed [PW-1:0]         aa_prod;
    logic signed [PW-1:0]         bb_prod;
    logic                         accept;
    logic                         pending;

    logic                         s1_valid_reg;
    logic                         s1_last_reg;
    logic                         s1_en_reg;
    logic signed [PW-1:0]         s1_ab_reg;
    logic [PW-1:0]                s1_aa_reg;
    logic [PW-1:0]                s1_bb_reg;
    logic [CW-1:0]                cnt_reg;

    logic signed [DOT_W-1:0]      dot_sum_reg;
    logic [SQ_W-1:0]              sqa_reg;
    logic [SQ_W-1:0]              sqb_reg;
    logic signed [DOT_W-1:0]      dot_next;
    logic [SQ_W-1:0]              sqa_next;
    logic [SQ_W-1:0]              sqb_next;
    logic signed [AW-1:0]         dot_wide;
    logic [AW-1:0]                sqa_wide;
    logic [AW-1:0]                sqb_wide;

    // Take the low SAMPLE_BITS of each element as two's complement
    assign a_ext = XW'($unsigned(elem_a));
    assign b_ext = XW'($unsigned(elem_b));
    assign a_s   = $signed(a_ext[SAMPLE_BITS-1:0]);
    assign b_s   = $signed(b_ext[SAMPLE_BITS-1:0]);

    assign ab_prod = a_s * b_s;
    assign aa_prod = a_s * a_s;
    assign bb_prod = b_s * b_s;

    // Hold input while the queue could not take every vector end in flight
    assign pending  = s1_valid_reg & s1_last_reg;
    assign in_stall = ((LVL_W+1)'(level) + (LVL_W+1)'(pending)) >= (LVL_W+1)'(QUEUE_DEPTH);
    assign accept   = in_valid & ~in_stall;

    // Product stage control and element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_en_reg    <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_last_reg <= last;
                s1_en_reg   <= (cnt_reg < CW'(MAX_LENGTH));
                if (last)
                    cnt_reg <= '0;
                else if (cnt_reg < CW'(MAX_LENGTH))
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Product stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ab_reg <= ab_prod;
            s1_aa_reg <= $unsigned(aa_prod);
            s1_bb_reg <= $unsigned(bb_prod);
        end
    end

    // Add products into the sums and clamp at the accumulator limits
    always_comb
    begin
        dot_wide = AW'(dot_sum_reg) + AW'(s1_ab_reg);
        sqa_wide = AW'(sqa_reg) + AW'(s1_aa_reg);
        sqb_wide = AW'(sqb_reg) + AW'(s1_bb_reg);

        if (dot_wide > DOT_HI)
            dot_next = DOT_MAX_C;
        else if (dot_wide < DOT_LO)
            dot_next = DOT_MIN_C;
        else
            dot_next = DOT_W'(dot_wide);

        sqa_next = (sqa_wide > SQ_HI) ? SQ_MAX_C : SQ_W'(sqa_wide);
        sqb_next = (sqb_wide > SQ_HI) ? SQ_MAX_C : SQ_W'(sqb_wide);

        // Drop pairs beyond the maximum vector length
        if (!s1_en_reg)
        begin
            dot_next = dot_sum_reg;
            sqa_next = sqa_reg;
            sqb_next = sqb_reg;
        end
    end

    assign push                   = pending;
    assign push_data.dot_sum      = dot_next;
    assign push_data.square_sum_a = sqa_next;
    assign push_data.square_sum_b = sqb_next;

    // Accumulate, or clear once the vector end has been pushed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_sum_reg <= '0;
            sqa_reg     <= '0;
            sqb_reg     <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                dot_sum_reg <= '0;
                sqa_reg     <= '0;
                sqb_reg     <= '0;
            end
            else
            begin
                dot_sum_reg <= dot_next;
                sqa_reg     <= sqa_next;
                sqb_reg     <= sqb_next;
            end
        end
    end

endmodule

/* rtl/core/csim_queue.sv */
// Short queue of finished accumulator sets between front and back end.
// Register based, QUEUE_DEPTH entries. Uses csim_pkg.
module csim_queue
    import csim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  acc_entry_t       push_data,
    input  logic             pop,
    output logic             q_valid,
    output acc_entry_t       q_data,
    output logic [LVL_W-1:0] level
);

    acc_entry_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] count_reg;

    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign level   = count_reg;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/core/csim_back.sv */
// Back end: forms dot^2 and sa*sb by shift-add, then finds the Q1.15 quotient
// bit by bit with a restoring square-root-divide recurrence. Uses csim_pkg.
module csim_back
    import csim_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  acc_entry_t              q_data,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SIM_W-1:0] similarity,
    output logic                    zero_norm
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_ROOT,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    logic [SIM_W-1:0]    similarity_reg;
    logic                zero_norm_reg;

    logic [CNT_W-1:0]    step_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   p_acc_reg;
    logic [PROD_W-1:0]   d_acc_reg;
    logic [PROD_W-1:0]   mcand_p_reg;
    logic [PROD_W-1:0]   mcand_d_reg;
    logic [MAG_W-1:0]    mplier_p_reg;
    logic [MAG_W-1:0]    mplier_d_reg;
    logic [RW-1:0]       e_reg;
    logic [RW-1:0]       t1_reg;
    logic [RW-1:0]       t2_reg;
    logic [ROOT_BITS-1:0] q_reg;
    logic [SIM_W-1:0]    res_sim_reg;
    logic                res_zn_reg;

    logic                entry_zero;
    logic [MAG_W-1:0]    entry_mag;
    logic [RW-1:0]       trial;
    logic                fits;
    logic [ROOT_BITS-1:0] q_next;
    logic [SIM_W-1:0]    q_ext;
    logic                out_free;

    assign entry_zero = (q_data.square_sum_a == '0) || (q_data.square_sum_b == '0);
    assign entry_mag  = q_data.dot_sum[DOT_W-1] ? MAG_W'(-q_data.dot_sum)
                                                : MAG_W'(q_data.dot_sum);

    assign trial  = t1_reg + t2_reg;
    assign fits   = (trial <= e_reg);
    assign q_next = {q_reg[ROOT_BITS-2:0], fits};
    assign q_ext  = SIM_W'(q_next);

    assign pop      = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign similarity = $signed(similarity_reg);
    assign zero_norm  = zero_norm_reg;

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            similarity_reg <= '0;
            zero_norm_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                        state_reg <= entry_zero ? ST_DONE : ST_MUL;
                end
                ST_MUL:
                begin
                    if (step_reg == '0)
                        state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    state_reg <= (p_acc_reg <= d_acc_reg) ? ST_DONE : ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (step_reg == '0)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        similarity_reg <= res_sim_reg;
                        zero_norm_reg  <= res_zn_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: shift-add products, then quotient recurrence
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                neg_reg      <= q_data.dot_sum[DOT_W-1];
                p_acc_reg    <= '0;
                d_acc_reg    <= '0;
                mcand_p_reg  <= PROD_W'(q_data.square_sum_b);
                mplier_p_reg <= MAG_W'(q_data.square_sum_a);
                mcand_d_reg  <= PROD_W'(entry_mag);
                mplier_d_reg <= entry_mag;
                step_reg     <= CNT_W'(MAG_W - 1);
                res_sim_reg  <= '0;
                res_zn_reg   <= 1'b1;
            end
            ST_MUL:
            begin
                if (mplier_p_reg[0])
                    p_acc_reg <= p_acc_reg + mcand_p_reg;
                if (mplier_d_reg[0])
                    d_acc_reg <= d_acc_reg + mcand_d_reg;
                mcand_p_reg  <= mcand_p_reg << 1;
                mcand_d_reg  <= mcand_d_reg << 1;
                mplier_p_reg <= mplier_p_reg >> 1;
                mplier_d_reg <= mplier_d_reg >> 1;
                step_reg     <= step_reg - 1'b1;
            end
            ST_CHECK:
            begin
                // Full-scale quotient saturates
                res_sim_reg <= neg_reg ? SIM_MIN : SIM_MAX;
                res_zn_reg  <= 1'b0;
                e_reg       <= RW'(d_acc_reg) << ROOT_SHIFT;
                t1_reg      <= '0;
                t2_reg      <= RW'(p_acc_reg) << T2_SHIFT;
                q_reg       <= '0;
                step_reg    <= CNT_W'(ROOT_BITS - 1);
            end
            ST_ROOT:
            begin
                // Try the next quotient bit: trial = 2^(k+1)*q*P + 2^(2k)*P
                if (fits)
                begin
                    e_reg  <= e_reg - trial;
                    t1_reg <= (t1_reg >> 1) + t2_reg;
                end
                else
                begin
                    t1_reg <= t1_reg >> 1;
                end
                t2_reg      <= t2_reg >> 2;
                q_reg       <= q_next;
                res_sim_reg <= neg_reg ? (SIM_W'(0) - q_ext) : q_ext;
                res_zn_reg  <= 1'b0;
                step_reg    <= step_reg - 1'b1;
            end
            ST_DONE:
            begin
                res_zn_reg <= res_zn_reg;
            end
            default:
            begin
                res_zn_reg <= res_zn_reg;
            end
        endcase
    end

endmodule
